[design/delta_escape_series_encoder_assert.svh]
// Assertion macros shared by the encoder modules.
`ifndef DELTA_ESCAPE_SERIES_ENCODER_ASSERT_SVH
`define DELTA_ESCAPE_SERIES_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define DESE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dese assertion failed");
`define DESE_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("dese forbidden condition");
`else
`define DESE_ASSERT(name, clk, rst_n, prop)
`define DESE_NEVER(name, clk, rst_n, cond)
`endif

`endif

[design/dese_pkg.sv]
// Types and constants of the delta escape series encoder.
`timescale 1ns / 1ps
package dese_pkg;

  localparam int MAX_SAMPLES = 500;
  localparam int MAX_BYTES   = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int LEN_W       = 4;

  localparam logic [7:0] ESC_BYTE = 8'h7F;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

  typedef enum logic [1:0] {
    REG_FORMAT   = 2'd0,
    REG_MASK     = 2'd1,
    REG_COUNT    = 2'd2,
    REG_CAPACITY = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        fmt;
    logic [3:0]  mask;
    logic [8:0]  count;
    logic [15:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    logic                      ends_frame;
    logic                      ovf;
  } entry_t;

endpackage

[design/dese_front.sv]
// Front end: frame tracking, header and delta coding into byte words.
`timescale 1ns / 1ps
module dese_front import dese_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [15:0] s_data_i,
  input  logic        full_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [15:0] prev_q, prev_d;
  logic [8:0]  sidx_q, sidx_d;
  logic [2:0]  ser_q, ser_d;
  logic [15:0] bw_q, bw_d;
  logic        abort_q, abort_d;

  logic [8:0]  n0, n;
  logic [2:0]  nser;
  logic        empty, first, accept;
  logic [15:0] bw_base;
  logic        ab_base;
  logic [16:0] delta;
  logic        fits_byte;
  logic [MAX_BYTES-1:0][7:0] hdr;
  logic [3:0][7:0] pay;
  logic [LEN_W-1:0] hl, plen, len, pidx;
  logic        last_series, last_frame;
  logic [16:0] total;

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && !full_i;

  always_comb begin
    n0 = (cfg_i.count == 9'd0) ? 9'd1 : cfg_i.count;
    n  = ({7'd0, n0} > 16'(MAX_SAMPLES)) ? 9'(MAX_SAMPLES) : n0;
    if (cfg_i.fmt) begin
      nser = 3'(cfg_i.mask[0]) + 3'(cfg_i.mask[1]) + 3'(cfg_i.mask[2]) + 3'(cfg_i.mask[3]);
    end else begin
      nser = 3'd2;
    end
    empty = cfg_i.fmt && (nser == 3'd0);
    first = empty || ((sidx_q == 9'd0) && (ser_q == 3'd0));
    bw_base = first ? 16'd0 : bw_q;
    ab_base = first ? 1'b0 : abort_q;

    hdr    = '0;
    hdr[0] = CH_D;
    hdr[1] = CH_R;
    hdr[2] = CH_L;
    if (cfg_i.fmt) begin
      hdr[3] = CH_TWO;
      hdr[4] = {4'd0, cfg_i.mask};
      hdr[5] = {7'd0, n[8]};
      hdr[6] = n[7:0];
    end else begin
      hdr[3] = CH_ONE;
      hdr[4] = {7'd0, n[8]};
      hdr[5] = n[7:0];
    end
    hl = first ? (cfg_i.fmt ? LEN_W'(7) : LEN_W'(6)) : '0;

    delta = {s_data_i[15], s_data_i} - {prev_q[15], prev_q};
    fits_byte = ($signed(delta) >= -17'sd127) && ($signed(delta) <= 17'sd126);
    pay = '0;
    if (empty) begin
      plen = '0;
    end else if (sidx_q == 9'd0) begin
      pay[0] = s_data_i[15:8];
      pay[1] = s_data_i[7:0];
      plen   = LEN_W'(2);
    end else if (fits_byte) begin
      pay[0] = delta[7:0];
      plen   = LEN_W'(1);
    end else begin
      pay[0] = ESC_BYTE;
      pay[1] = delta[15:8];
      pay[2] = delta[7:0];
      plen   = LEN_W'(3);
    end
    len = hl + plen;

    entry_o = '0;
    for (int k = 0; k < MAX_BYTES; k++) begin
      pidx = LEN_W'(k) - hl;
      if (LEN_W'(k) < hl) begin
        entry_o.bytes[k] = hdr[k];
      end else if (pidx < plen) begin
        entry_o.bytes[k] = pay[pidx[1:0]];
      end
    end

    last_series = empty || ({1'b0, sidx_q} + 10'd1 >= {1'b0, n});
    last_frame  = empty || (last_series && ({1'b0, ser_q} + 4'd1 >= {1'b0, nser}));
    total = {1'b0, bw_base} + 17'(len);

    prev_d  = empty ? prev_q : s_data_i;
    sidx_d  = last_series ? 9'd0 : sidx_q + 9'd1;
    ser_d   = last_series ? (last_frame ? 3'd0 : ser_q + 3'd1) : ser_q;
    bw_d    = bw_base;
    abort_d = ab_base;
    push_o  = 1'b0;
    entry_o.len        = len;
    entry_o.ends_frame = last_frame;
    entry_o.ovf        = 1'b0;
    if (!ab_base) begin
      push_o = accept;
      if (total > {1'b0, cfg_i.capacity}) begin
        abort_d            = 1'b1;
        entry_o.bytes      = '0;
        entry_o.len        = LEN_W'(1);
        entry_o.ends_frame = 1'b0;
        entry_o.ovf        = 1'b1;
      end else begin
        bw_d = total[15:0];
      end
    end
    if (last_frame) begin
      abort_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      sidx_q  <= '0;
      ser_q   <= '0;
      bw_q    <= '0;
      abort_q <= 1'b0;
    end else if (accept) begin
      prev_q  <= prev_d;
      sidx_q  <= sidx_d;
      ser_q   <= ser_d;
      bw_q    <= bw_d;
      abort_q <= abort_d;
    end
  end

endmodule

[design/dese_queue.sv]
// Short word queue between the front end and the byte serializer.
`timescale 1ns / 1ps
`include "delta_escape_series_encoder_assert.svh"
module dese_queue import dese_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  `DESE_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o)
  `DESE_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o)

endmodule

[design/dese_back.sv]
// Back end: serializes queued words one byte per cycle while the sink is ready.
`timescale 1ns / 1ps
`include "delta_escape_series_encoder_assert.svh"
module dese_back import dese_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] m_data_o,
  output logic       m_last_o,
  output logic [1:0] m_user_o
);

  entry_t           ent_q;
  logic             busy_q;
  logic [LEN_W-1:0] idx_q;
  logic             last, take, done;

  assign last      = (idx_q == ent_q.len - LEN_W'(1));
  assign m_valid_o = busy_q;
  assign m_data_o  = ent_q.bytes[idx_q];
  assign m_last_o  = last && ent_q.ends_frame;
  assign m_user_o  = {ent_q.ovf, last};
  assign take      = busy_q && m_ready_i;
  assign done      = !busy_q || (take && last);
  assign pop_o     = done && !empty_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + LEN_W'(1);
    end
  end

  `DESE_ASSERT(a_len_range, clk_i, rst_ni,
    busy_q |-> (ent_q.len != '0 && ent_q.len <= LEN_W'(MAX_BYTES)))
  `DESE_ASSERT(a_idx_in_word, clk_i, rst_ni, busy_q |-> (idx_q < ent_q.len))
  `DESE_ASSERT(a_ovf_single, clk_i, rst_ni,
    (busy_q && ent_q.ovf) |-> (ent_q.len == LEN_W'(1) && !m_last_o))

endmodule

[design/delta_escape_series_encoder.sv]
// Delta escape series encoder: 16-bit samples in, DRL1/DRL2 coded bytes out, one
// byte per cycle while the sink is ready. A sample is accepted every cycle while the
// word queue has room; each sample becomes 0 to 9 bytes (typically 1, 3 for an escaped
// delta, plus a 6- or 7-byte header on the first sample of a frame), so the sustained
// sample rate is set by the single-byte output serializer. tuser carries item_last
// (bit 0) and overflow (bit 1); tlast marks the frame end. The user must write the
// registers over APB only while the stream is idle; the block does not enforce this.
`timescale 1ns / 1ps
module delta_escape_series_encoder import dese_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,   // frame_end
  output logic [1:0]  m_axis_tuser_o    // [0] item_last, [1] overflow
);

  cfg_t     cfg_q;
  reg_idx_e widx;
  logic     wr_en;
  logic     push, full, pop, empty;
  entry_t   push_data, head;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt      <= 1'b0;
      cfg_q.mask     <= 4'd3;
      cfg_q.count    <= 9'd500;
      cfg_q.capacity <= 16'hFFFF;
    end else if (wr_en) begin
      case (widx)
        REG_FORMAT:   cfg_q.fmt      <= pwdata[0];
        REG_MASK:     cfg_q.mask     <= pwdata[3:0];
        REG_COUNT:    cfg_q.count    <= pwdata[8:0];
        REG_CAPACITY: cfg_q.capacity <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_FORMAT:   prdata = {31'd0, cfg_q.fmt};
      REG_MASK:     prdata = {28'd0, cfg_q.mask};
      REG_COUNT:    prdata = {23'd0, cfg_q.count};
      REG_CAPACITY: prdata = {16'd0, cfg_q.capacity};
      default:      prdata = '0;
    endcase
  end

  dese_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_data)
  );

  dese_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  dese_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o),
    .m_user_o  (m_axis_tuser_o)
  );

endmodule

[sim/tb_delta_escape_series_encoder.sv]
// Testbench for the delta escape series encoder: random and directed samples, scoreboard.
`timescale 1ns / 1ps
module tb_delta_escape_series_encoder import dese_pkg::*;;

  typedef struct packed {
    logic [7:0] data;
    logic       item_last;
    logic       frame_end;
    logic       ovf;
  } enc_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // [15:0] sample_value
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [7:0] out_byte
  logic        m_axis_tlast_o;        // frame_end
  logic [1:0]  m_axis_tuser_o;        // [0] item_last, [1] overflow

  // register shadow and encoder state mirror
  cfg_t        shadow_cfg = '{fmt: 1'b0, mask: 4'd3, count: 9'd500, capacity: 16'hFFFF};
  logic [15:0] prev_sample = '0;
  logic [8:0]  samp_idx = '0;
  logic [2:0]  ser_idx = '0;
  logic [15:0] frame_bytes = '0;
  logic        aborted = 1'b0;

  logic [15:0] sample_q[$];
  enc_word_t   pending_bytes[$];
  logic [15:0] gen_prev = '0;

  int  items_queued = 0;
  int  items_taken = 0;
  int  err_cnt = 0;
  int  n_bytes = 0;
  int  n_frames = 0;
  int  n_ovf = 0;
  int  n_settings = 0;
  int  in_gap = 0;
  int  out_wait = 0;
  int  hold_left = 0;
  bit  in_idle_on = 1'b0;
  bit  out_idle_on = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;

  delta_escape_series_encoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void expect_bytes(input logic [7:0] seq[$], input logic ends);
    for (int k = 0; k < seq.size(); k++) begin
      pending_bytes.push_back('{data: seq[k], item_last: k == seq.size() - 1,
                                frame_end: (k == seq.size() - 1) && ends, ovf: 1'b0});
    end
  endfunction

  function automatic void encode_sample(input logic [15:0] sv);
    logic [7:0] seq[$];
    int         n;
    int         nser;
    int         d;
    logic [15:0] ud;
    logic       empty;
    logic       end_series;
    logic       end_frame;
    n = (shadow_cfg.count == 0) ? 1 : int'(shadow_cfg.count);
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    nser = shadow_cfg.fmt ? $countones(shadow_cfg.mask) : 2;
    empty = shadow_cfg.fmt && (nser == 0);
    if (empty || (samp_idx == 0 && ser_idx == 0)) begin
      frame_bytes = '0;
      aborted = 1'b0;
      seq = '{CH_D, CH_R, CH_L};
      seq.push_back(shadow_cfg.fmt ? CH_TWO : CH_ONE);
      if (shadow_cfg.fmt) seq.push_back({4'd0, shadow_cfg.mask});
      seq.push_back(8'(n >> 8));
      seq.push_back(8'(n));
    end
    // empty mask: header-only frame per word, sample dropped
    if (empty) begin
      samp_idx = '0;
      ser_idx = '0;
      if (shadow_cfg.capacity < 7)
        pending_bytes.push_back('{data: 8'h00, item_last: 1'b1, frame_end: 1'b0, ovf: 1'b1});
      else
        expect_bytes(seq, 1'b1);
      return;
    end
    if (samp_idx == 0) begin
      seq.push_back(sv[15:8]);
      seq.push_back(sv[7:0]);
    end else begin
      d = int'($signed(sv)) - int'($signed(prev_sample));
      ud = 16'(d);
      if (d >= -127 && d <= 126) begin
        seq.push_back(ud[7:0]);
      end else begin
        seq.push_back(ESC_BYTE);
        seq.push_back(ud[15:8]);
        seq.push_back(ud[7:0]);
      end
    end
    prev_sample = sv;
    end_series = (int'(samp_idx) + 1 >= n);
    end_frame = end_series && (int'(ser_idx) + 1 >= nser);
    if (end_series) begin
      samp_idx = '0;
      ser_idx = end_frame ? 3'd0 : ser_idx + 3'd1;
    end else begin
      samp_idx = samp_idx + 9'd1;
    end
    if (!aborted) begin
      if (int'(frame_bytes) + seq.size() > int'(shadow_cfg.capacity)) begin
        aborted = 1'b1;
        pending_bytes.push_back('{data: 8'h00, item_last: 1'b1, frame_end: 1'b0, ovf: 1'b1});
      end else begin
        frame_bytes = frame_bytes + 16'(seq.size());
        expect_bytes(seq, end_frame);
      end
    end
    if (end_frame) aborted = 1'b0;
  endfunction

  // input acceptance, prediction and output check
  always @(posedge clk_i) begin
    in_acc <= s_axis_tvalid_i && s_axis_tready_o;
    out_acc <= m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        encode_sample(s_axis_tdata_i);
        items_taken++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_bytes++;
        if (m_axis_tlast_o) n_frames++;
        if (m_axis_tuser_o[1]) n_ovf++;
        if (pending_bytes.size() == 0) begin
          $error("unexpected word: out_byte %0h", m_axis_tdata_o);
          err_cnt++;
        end else begin
          enc_word_t exp_w;
          exp_w = pending_bytes.pop_front();
          if (m_axis_tdata_o !== exp_w.data) begin
            $error("out_byte: expected %0h, got %0h", exp_w.data, m_axis_tdata_o);
            err_cnt++;
          end
          if (m_axis_tuser_o[0] !== exp_w.item_last) begin
            $error("item_last: expected %0b, got %0b", exp_w.item_last, m_axis_tuser_o[0]);
            err_cnt++;
          end
          if (m_axis_tlast_o !== exp_w.frame_end) begin
            $error("frame_end: expected %0b, got %0b", exp_w.frame_end, m_axis_tlast_o);
            err_cnt++;
          end
          if (m_axis_tuser_o[1] !== exp_w.ovf) begin
            $error("overflow: expected %0b, got %0b", exp_w.ovf, m_axis_tuser_o[1]);
            err_cnt++;
          end
        end
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_acc)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_axis_tdata_i <= sample_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        in_gap = in_idle_on ? $urandom_range(0, 6) : 0;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // byte sink with per-byte stalls and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 299;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (out_acc) out_wait = out_idle_on ? $urandom_range(0, 6) : 0;
        if (out_wait > 0) begin
          out_wait--;
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_FORMAT:   shadow_cfg.fmt = val[0];
      REG_MASK:     shadow_cfg.mask = val[3:0];
      REG_COUNT:    shadow_cfg.count = val[8:0];
      REG_CAPACITY: shadow_cfg.capacity = val[15:0];
      default: ;
    endcase
  endtask

  task automatic push_sample(input logic [15:0] v);
    sample_q.push_back(v);
    items_queued++;
    gen_prev = v;
  endtask

  // accepted items may still be in flight without output: pause past the pipeline
  task automatic wait_idle();
    while (items_taken != items_queued || pending_bytes.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample(input logic [15:0] last_v);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return last_v + 16'($urandom_range(0, 260)) - 16'd130;
      5:             return last_v + 16'd126 + 16'($urandom_range(0, 1));
      6:             return last_v - 16'd127 - 16'($urandom_range(0, 1));
      7:             return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default:       return 16'($urandom);
    endcase
  endfunction

  initial begin
    int   rand_items;
    int   n_eff;
    int   nser;
    int   flen;
    int   frames;
    int   n_items;
    cfg_t nc;
    rand_items = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // two-series format, deltas at the single/escape boundaries, full-range jumps
    write_reg(REG_FORMAT, 0);
    write_reg(REG_COUNT, 5);
    write_reg(REG_CAPACITY, 32'hFFFF);
    n_settings++;
    push_sample(16'h0000); push_sample(16'd126); push_sample(16'd253);
    push_sample(16'd126);  push_sample(16'd126);
    push_sample(16'h7FFF); push_sample(16'h7F7F); push_sample(16'h8000);
    push_sample(16'h7FFF); push_sample(16'h7FFF);
    wait_idle();

    // zero count acts as one
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    write_reg(REG_COUNT, 0);
    n_settings++;
    push_sample(16'hFFFF); push_sample(16'h0000);
    push_sample(16'h1234); push_sample(16'hEDCB);
    wait_idle();

    // masked format with empty mask, then below header size
    write_reg(REG_FORMAT, 1);
    write_reg(REG_MASK, 0);
    n_settings++;
    push_sample(16'h5555); push_sample(16'hAAAA);
    wait_idle();
    write_reg(REG_CAPACITY, 6);
    n_settings++;
    push_sample(16'h0001);
    wait_idle();

    // clamped count, capacity exactly the first word, then shrink count mid-frame
    write_reg(REG_MASK, 15);
    write_reg(REG_COUNT, 511);
    write_reg(REG_CAPACITY, 9);
    n_settings++;
    push_sample(16'h8000); push_sample(16'h8001); push_sample(16'h0000);
    wait_idle();
    write_reg(REG_COUNT, 1);
    n_settings++;
    push_sample(16'h0100); push_sample(16'h0200); push_sample(16'h0300); push_sample(16'h0400);
    wait_idle();

    while (rand_items < 396) begin
      n_settings++;
      nc.fmt = 1'($urandom_range(0, 1));
      nc.mask = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        7:       nc.count = 9'd0;
        8, 9:    nc.count = 9'($urandom_range(7, 20));
        default: nc.count = 9'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 3))
        0:       nc.capacity = 16'($urandom_range(0, 12));
        1:       nc.capacity = 16'($urandom_range(8, 60));
        2:       nc.capacity = 16'hFFFF;
        default: nc.capacity = 16'($urandom);
      endcase
      // the long sink hold-off needs every sample to produce bytes
      if (n_settings == 10) nc.capacity = 16'hFFFF;
      write_reg(REG_FORMAT, 32'(nc.fmt));
      write_reg(REG_MASK, 32'(nc.mask));
      write_reg(REG_COUNT, 32'(nc.count));
      write_reg(REG_CAPACITY, 32'(nc.capacity));
      n_eff = (nc.count == 0) ? 1 : int'(nc.count);
      nser = nc.fmt ? $countones(nc.mask) : 2;
      flen = (nser == 0) ? 1 : n_eff * nser;
      frames = $urandom_range(1, 3);
      if (flen * frames > 60) frames = 1;
      n_items = flen * frames;
      // occasional partial frame carried into the next setting
      if ($urandom_range(0, 4) == 0) n_items += $urandom_range(1, 2);
      in_idle_on = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      if (n_settings == 10) begin
        hold_go = 1'b1;
        if (n_items < 24) n_items = 24;
      end
      repeat (n_items) begin
        push_sample(pick_sample(gen_prev));
        rand_items++;
      end
      wait_idle();
    end

    wait_idle();
    if (pending_bytes.size() != 0) begin
      $error("%0d expected words never arrived", pending_bytes.size());
      err_cnt++;
    end
    $display("run: %0d samples over %0d register settings, %0d bytes out",
             items_taken, n_settings, n_bytes);
    $display("run: %0d frames closed, %0d overflow words", n_frames, n_ovf);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/dese_pkg.sv
design/dese_front.sv
design/dese_queue.sv
design/dese_back.sv
design/delta_escape_series_encoder.sv
sim/tb_delta_escape_series_encoder.sv
